// File: rtl/clab_pkg.sv
// clab_pkg: shared types and constants for the CPU load affinity balancer.
// Holds the table sizes, the input and result word structs, action and register
// codes, and the command/status structs that join the controller and the datapath.
`timescale 1ns / 1ps

package clab_pkg;

  // table sizes; the word fields below are sized for these
  localparam int NUM_CPUS  = 8;
  localparam int NUM_PROCS = 64;

  // action codes of the input word
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_CLEAR    = 3'd1;
  localparam logic [2:0] ACT_DISPATCH = 3'd2;
  localparam logic [2:0] ACT_SET_RUN  = 3'd3;
  localparam logic [2:0] ACT_CHECK    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_COOLDOWN  = 2'd1;

  // reset values of the configuration registers
  localparam logic [7:0]  THRESHOLD_RESET = 8'd2;
  localparam logic [15:0] COOLDOWN_RESET  = 16'd20;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] proc_index;
    logic [2:0] cpu_index;
    logic       runnable_flag;
  } item_t;

  typedef struct packed {
    logic        check_done;
    logic        migrated;
    logic [5:0]  migrated_proc;
    logic [2:0]  source_cpu;
    logic [15:0] source_load;
    logic [15:0] own_load;
  } result_t;

  // load memory read address select
  typedef enum logic [1:0] {
    LR_SCAN,
    LR_DEC,
    LR_CPU
  } lrd_sel_t;

  // load memory update
  typedef enum logic {
    LW_DEC,
    LW_INC
  } lw_op_t;

  // affinity memory update
  typedef enum logic [1:0] {
    AW_INVAL,
    AW_SET,
    AW_MIG
  } aw_op_t;

  // process table read address select
  typedef enum logic {
    PR_SCAN,
    PR_PROC
  } prd_sel_t;

  typedef struct packed {
    logic     capture;
    logic     clr;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     tick_inc;
    logic     stamp;
    logic     lrd_en;
    lrd_sel_t lrd_sel;
    logic     lscan;
    logic     lwr_en;
    lw_op_t   lw_op;
    logic     prd_en;
    prd_sel_t prd_sel;
    logic     pscan;
    logic     awr_en;
    aw_op_t   aw_op;
    logic     rwr_en;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       p_ok;
    logic       c_ok;
    logic       cool_ok;
    logic       same;
    logic       aff_valid;
    logic       lead_ok;
    logic       hit;
    logic       cnt_last_cpu;
    logic       cnt_last_proc;
    logic       cnt_last_clr;
  } status_t;

endpackage

// File: rtl/clab_ctrl.sv
// clab_ctrl: sequencer for the balancer; clearing pass, per-action steps,
// load scan and process scan of a balance check. Uses clab_pkg.
`timescale 1ns / 1ps

module clab_ctrl
  import clab_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_DEVAL,
    S_LSCAN,
    S_LDRAIN,
    S_LEAD,
    S_PSCAN,
    S_PDRAIN,
    S_PEND,
    S_MIG,
    S_DEC,
    S_INC,
    S_DONE
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_clr) begin
          cmd.cnt_clr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (stat.action)
          ACT_TICK: cmd.tick_inc = 1'b1;
          ACT_CLEAR: begin
            if (stat.p_ok) begin
              cmd.awr_en = 1'b1;
              cmd.aw_op = AW_INVAL;
            end
          end
          ACT_DISPATCH: begin
            if (stat.p_ok && stat.c_ok) begin
              cmd.prd_en = 1'b1;
              cmd.prd_sel = PR_PROC;
              state_next = S_DEVAL;
            end
          end
          ACT_SET_RUN: cmd.rwr_en = stat.p_ok;
          ACT_CHECK: begin
            if (stat.c_ok && stat.cool_ok) begin
              cmd.stamp = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_next = S_LSCAN;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DEVAL: begin
        cmd.awr_en = 1'b1;
        cmd.aw_op = AW_SET;
        if (stat.same) begin
          state_next = S_DONE;
        end else if (stat.aff_valid) begin
          cmd.lrd_en = 1'b1;
          cmd.lrd_sel = LR_DEC;
          state_next = S_DEC;
        end else begin
          cmd.lrd_en = 1'b1;
          cmd.lrd_sel = LR_CPU;
          state_next = S_INC;
        end
      end
      // one load word read per cycle
      S_LSCAN: begin
        cmd.lrd_en = 1'b1;
        cmd.lrd_sel = LR_SCAN;
        cmd.lscan = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_cpu) begin
          cmd.cnt_clr = 1'b1;
          state_next = S_LDRAIN;
        end
      end
      S_LDRAIN: state_next = S_LEAD;
      S_LEAD: begin
        cmd.cnt_clr = 1'b1;
        state_next = stat.lead_ok ? S_PSCAN : S_DONE;
      end
      // one process entry per cycle, stop at first match
      S_PSCAN: begin
        if (stat.hit) begin
          state_next = S_MIG;
        end else begin
          cmd.prd_en = 1'b1;
          cmd.prd_sel = PR_SCAN;
          cmd.pscan = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.cnt_last_proc) begin
            state_next = S_PDRAIN;
          end
        end
      end
      S_PDRAIN: state_next = S_PEND;
      S_PEND: state_next = stat.hit ? S_MIG : S_DONE;
      S_MIG: begin
        cmd.awr_en = 1'b1;
        cmd.aw_op = AW_MIG;
        cmd.lrd_en = 1'b1;
        cmd.lrd_sel = LR_DEC;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.lwr_en = 1'b1;
        cmd.lw_op = LW_DEC;
        cmd.lrd_en = 1'b1;
        cmd.lrd_sel = LR_CPU;
        state_next = S_INC;
      end
      S_INC: begin
        cmd.lwr_en = 1'b1;
        cmd.lw_op = LW_INC;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
      done <= (state_next == S_DONE);
    end
  end

endmodule

// File: rtl/clab_dpath.sv
// clab_dpath: balancer datapath; load memory, process affinity and runnable
// memories, tick and stamp counters, config registers, scan and result regs.
// Uses clab_pkg; driven by clab_ctrl.
`timescale 1ns / 1ps

module clab_dpath
  import clab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output status_t     stat,
  output result_t     result
);

  localparam int CW   = $clog2(NUM_CPUS);
  localparam int PW   = $clog2(NUM_PROCS);
  localparam int MAXN = (NUM_CPUS > NUM_PROCS) ? NUM_CPUS : NUM_PROCS;
  localparam int CNTW = $clog2(MAXN);

  // configuration
  logic [7:0]  thr;
  logic [15:0] cool;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESHOLD_RESET;
      cool <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr <= cfg_data[7:0];
        CFG_COOLDOWN:  cool <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input word
  item_t item_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_q <= item;
  end

  logic [CW-1:0] cpu_a;
  logic [PW-1:0] proc_a;
  assign cpu_a = CW'(item_q.cpu_index);
  assign proc_a = PW'(item_q.proc_index);

  // shared scan / clear counter
  logic [CNTW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  logic cnt_in_cpus;
  assign cnt_in_cpus = ({1'b0, cnt} < (CNTW + 1)'(NUM_CPUS));

  // time keeping
  logic [31:0] tick_count, last_check;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      last_check <= '0;
    end else begin
      if (cmd.tick_inc) tick_count <= tick_count + 32'd1;
      if (cmd.stamp) last_check <= tick_count;
    end
  end

  // process table: {valid, cpu} and runnable flag, read at one address
  logic [CW:0]   aff_mem [NUM_PROCS];
  logic          run_mem [NUM_PROCS];
  logic [CW:0]   pdata;
  logic          prun;
  logic [PW-1:0] prd_addr, awr_addr;
  logic [CW:0]   awr_data;
  logic [PW-1:0] hit_idx;

  always_comb begin
    prd_addr = (cmd.prd_sel == PR_SCAN) ? cnt[PW-1:0] : proc_a;
    awr_addr = proc_a;
    awr_data = {1'b1, cpu_a};
    case (cmd.aw_op)
      AW_INVAL: awr_data = {1'b0, cpu_a};
      AW_SET:   awr_data = {1'b1, cpu_a};
      AW_MIG:   awr_addr = hit_idx;
      default:  awr_data = {1'b1, cpu_a};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      aff_mem[cnt[PW-1:0]] <= '0;
      run_mem[cnt[PW-1:0]] <= 1'b0;
    end else begin
      if (cmd.awr_en) aff_mem[awr_addr] <= awr_data;
      if (cmd.rwr_en) run_mem[proc_a] <= item_q.runnable_flag;
    end
    if (cmd.prd_en) begin
      pdata <= aff_mem[prd_addr];
      prun <= run_mem[prd_addr];
    end
  end

  // load counts, one read and one write port
  logic [15:0]   load_mem [NUM_CPUS];
  logic [15:0]   lrd;
  logic [CW-1:0] lrd_addr, lwr_addr, dec_cpu;
  logic [15:0]   lwr_data;
  logic          lwr_en;
  logic [CW-1:0] best;

  assign dec_cpu = (item_q.action == ACT_CHECK) ? best : pdata[CW-1:0];

  always_comb begin
    case (cmd.lrd_sel)
      LR_SCAN: lrd_addr = cnt[CW-1:0];
      LR_DEC:  lrd_addr = dec_cpu;
      LR_CPU:  lrd_addr = cpu_a;
      default: lrd_addr = cpu_a;
    endcase
    lwr_en = cmd.lwr_en;
    if (cmd.clr) begin
      lwr_en = cnt_in_cpus;
      lwr_addr = cnt[CW-1:0];
      lwr_data = '0;
    end else if (cmd.lw_op == LW_DEC) begin
      lwr_addr = dec_cpu;
      lwr_data = (lrd != 16'd0) ? lrd - 16'd1 : lrd;
    end else begin
      lwr_addr = cpu_a;
      lwr_data = (lrd != 16'hFFFF) ? lrd + 16'd1 : lrd;
    end
  end

  always_ff @(posedge clk) begin
    if (lwr_en) load_mem[lwr_addr] <= lwr_data;
    if (cmd.lrd_en) lrd <= load_mem[lrd_addr];
  end

  // scan tracking: read data arrives in the cycle after the address
  logic            lscan_q, pscan_q;
  logic [CNTW-1:0] sidx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      lscan_q <= 1'b0;
      pscan_q <= 1'b0;
    end else begin
      lscan_q <= cmd.lscan;
      pscan_q <= cmd.pscan;
    end
    sidx_q <= cnt;
  end

  // check result registers
  logic        chk, found, hit;
  logic [15:0] best_load, own_load;

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      chk <= 1'b0;
      found <= 1'b0;
      hit <= 1'b0;
      best <= '0;
      best_load <= '0;
      own_load <= '0;
      hit_idx <= '0;
    end else begin
      if (cmd.stamp) chk <= 1'b1;
      // busiest other CPU, lowest index on ties, load above zero
      if (lscan_q) begin
        if (sidx_q[CW-1:0] == cpu_a) begin
          own_load <= lrd;
        end else if (lrd > best_load) begin
          best_load <= lrd;
          best <= sidx_q[CW-1:0];
          found <= 1'b1;
        end
      end
      // first runnable process bound to the busiest CPU
      if (pscan_q && !hit && prun && pdata[CW] && (pdata[CW-1:0] == best)) begin
        hit <= 1'b1;
        hit_idx <= sidx_q[PW-1:0];
      end
    end
  end

  // status to the controller
  always_comb begin
    stat.action = item_q.action;
    stat.p_ok = (32'(item_q.proc_index) < NUM_PROCS);
    stat.c_ok = (32'(item_q.cpu_index) < NUM_CPUS);
    stat.cool_ok = ((tick_count - last_check) >= {16'd0, cool});
    stat.same = pdata[CW] && (pdata[CW-1:0] == cpu_a);
    stat.aff_valid = pdata[CW];
    stat.lead_ok = found && ({1'b0, best_load} >= ({1'b0, own_load} + {9'd0, thr}));
    stat.hit = hit;
    stat.cnt_last_cpu = (cnt == CNTW'(NUM_CPUS - 1));
    stat.cnt_last_proc = (cnt == CNTW'(NUM_PROCS - 1));
    stat.cnt_last_clr = (cnt == CNTW'(MAXN - 1));
  end

  // result word
  always_comb begin
    result.check_done = chk;
    result.migrated = hit;
    result.migrated_proc = 6'(hit_idx);
    result.source_cpu = 3'(best);
    result.source_load = best_load;
    result.own_load = own_load;
  end

endmodule

// File: rtl/cpu_load_affinity_balancer_unit.sv
// cpu_load_affinity_balancer_unit: top level of the idle-CPU pull balancer.
// Joins clab_ctrl and clab_dpath; uses clab_pkg.
`timescale 1ns / 1ps

// One word at a time: a word is taken on a clock edge with start high and
// busy low, and its result word is on result when done is high for exactly one cycle;
// there is no way to hold it off, so capture it on that edge.
// Every word gives one result (all zero unless a balance check ran).
// A balance check that runs reads the load memory one CPU per cycle, then
// the process table one entry per cycle, through single read ports. After
// reset a clearing pass over max(NUM_CPUS, NUM_PROCS) entries runs with
// busy high; configuration writes are taken at any time.
module cpu_load_affinity_balancer_unit
  import clab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t    cmd;
  status_t stat;

  // sequencer
  clab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // memories, counters and result registers
  clab_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

// File: test/cpu_load_affinity_balancer_unit_tb.sv
// cpu_load_affinity_balancer_unit_tb: self-checking bench for the idle-CPU pull balancer.
// Carries its own copy of the balancer state and compares every result word against it.
// Depends on clab_pkg and cpu_load_affinity_balancer_unit.
`timescale 1ns / 1ps

module cpu_load_affinity_balancer_unit_tb
  import clab_pkg::*;
;

  // Mirror of the balancer: loads, process table, tick stamps, plus the queue of
  // result words still owed by the block.
  class balancer_ledger;
    logic [15:0] core_load [NUM_CPUS];
    logic [2:0]  owner_cpu [NUM_PROCS];
    bit          owner_valid [NUM_PROCS];
    bit          ready [NUM_PROCS];
    logic [31:0] ticks;
    logic [31:0] last_stamp;
    logic [7:0]  threshold;
    logic [15:0] cooldown;
    result_t     owed [$];
    int unsigned failures;

    function new();
      for (int i = 0; i < NUM_CPUS; i++) core_load[i] = '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        owner_cpu[i] = '0;
        owner_valid[i] = 1'b0;
        ready[i] = 1'b0;
      end
      ticks = '0;
      last_stamp = '0;
      threshold = THRESHOLD_RESET;
      cooldown = COOLDOWN_RESET;
      failures = 0;
    endfunction

    function void set_regs(logic [7:0] thr, logic [15:0] cool);
      threshold = thr;
      cooldown = cool;
    endfunction

    // saturating load counters
    function void load_up(int c);
      if (core_load[c] != 16'hFFFF) core_load[c] = core_load[c] + 16'd1;
    endfunction

    function void load_down(int c);
      if (core_load[c] != 16'h0000) core_load[c] = core_load[c] - 16'd1;
    endfunction

    // apply one word to the mirror and return the result word it should give
    function result_t step_word(item_t w);
      result_t     r;
      logic [31:0] elapsed;
      int          idle_cpu;
      int          p;
      int          busiest;
      int          top_load;
      int          own;
      r = '0;
      idle_cpu = int'(w.cpu_index);
      p = int'(w.proc_index);
      case (w.action)
        ACT_TICK: begin
          ticks = ticks + 32'd1;
        end
        ACT_CLEAR: begin
          owner_valid[p] = 1'b0;
        end
        ACT_DISPATCH: begin
          if (!(owner_valid[p] && owner_cpu[p] == w.cpu_index)) begin
            if (owner_valid[p]) load_down(int'(owner_cpu[p]));
            load_up(idle_cpu);
          end
          owner_cpu[p] = w.cpu_index;
          owner_valid[p] = 1'b1;
        end
        ACT_SET_RUN: begin
          ready[p] = w.runnable_flag;
        end
        ACT_CHECK: begin
          elapsed = ticks - last_stamp;
          if (elapsed >= {16'd0, cooldown}) begin
            own = int'(core_load[idle_cpu]);
            busiest = -1;
            top_load = 0;
            // lowest index wins a tie; zero load is never picked
            for (int i = 0; i < NUM_CPUS; i++) begin
              if (i != idle_cpu && int'(core_load[i]) > top_load) begin
                top_load = int'(core_load[i]);
                busiest = i;
              end
            end
            last_stamp = ticks;
            r.check_done = 1'b1;
            r.own_load = own[15:0];
            if (busiest >= 0) begin
              r.source_cpu = busiest[2:0];
              r.source_load = top_load[15:0];
            end
            if (busiest >= 0 && top_load - own >= int'(threshold)) begin
              for (int i = 0; i < NUM_PROCS && !r.migrated; i++) begin
                if (ready[i] && owner_valid[i] && owner_cpu[i] == busiest[2:0]) begin
                  load_down(busiest);
                  load_up(idle_cpu);
                  owner_cpu[i] = w.cpu_index;
                  r.migrated = 1'b1;
                  r.migrated_proc = i[5:0];
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_word(item_t w);
      owed.push_back(step_word(w));
    endfunction

    function void compare_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, fname, want_v, got_v);
        failures++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        $display("%0t: result word with none owed, expected none actual %h", $time, got);
        failures++;
        return;
      end
      want = owed.pop_front();
      compare_field("check_done", 16'(want.check_done), 16'(got.check_done));
      compare_field("migrated", 16'(want.migrated), 16'(got.migrated));
      compare_field("migrated_proc", 16'(want.migrated_proc), 16'(got.migrated_proc));
      compare_field("source_cpu", 16'(want.source_cpu), 16'(got.source_cpu));
      compare_field("source_load", want.source_load, got.source_load);
      compare_field("own_load", want.own_load, got.own_load);
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  balancer_ledger ledger;
  int unsigned    quiet_cycles = 0;

  cpu_load_affinity_balancer_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result check, input capture and stall watchdog, all at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) ledger.match_result(result);
      if (start && !busy) ledger.note_word(item);
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("cpu_load_affinity_balancer_unit_tb: errors");
        $finish;
      end
    end
  end

  function automatic item_t mk(logic [2:0] a, logic [5:0] p, logic [2:0] c, logic f);
    item_t w;
    w.action = a;
    w.proc_index = p;
    w.cpu_index = c;
    w.runnable_flag = f;
    return w;
  endfunction

  // mostly legal traffic; dispatches lean toward one hot CPU to build imbalance
  function automatic item_t rand_word(logic [2:0] hot_cpu);
    item_t w;
    int    pick;
    w = '0;
    pick = $urandom_range(99);
    w.proc_index = ($urandom_range(9) < 7) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
    w.cpu_index = 3'($urandom_range(7));
    w.runnable_flag = ($urandom_range(9) < 7);
    if (pick < 30) w.action = ACT_TICK;
    else if (pick < 55) begin
      w.action = ACT_DISPATCH;
      if ($urandom_range(1)) w.cpu_index = hot_cpu;
    end else if (pick < 70) w.action = ACT_SET_RUN;
    else if (pick < 75) w.action = ACT_CLEAR;
    else if (pick < 95) w.action = ACT_CHECK;
    else w.action = 3'($urandom_range(32'(ACT_SPARE_FIRST), 32'(ACT_SPARE_LAST)));
    return w;
  endfunction

  // optional random gap, then hold the word until the block takes it
  task automatic send_word(item_t w, int idle_pct);
    int gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // drain: every word owes one result, so an empty queue and busy low means idle
  task automatic settle();
    start <= 1'b0;
    while (ledger.owed.size() != 0 || busy) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // back-to-back writes keep cfg_we high across both registers
  task automatic write_regs(logic [7:0] thr, logic [15:0] cool);
    cfg_we <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data <= {8'd0, thr};
    @(negedge clk);
    cfg_index <= CFG_COOLDOWN;
    cfg_data <= cool;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.set_regs(thr, cool);
  endtask

  task automatic run_random(int count, int idle_pct);
    logic [2:0] hot = 3'($urandom_range(7));
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 49) hot = 3'($urandom_range(7));
      send_word(rand_word(hot), idle_pct);
    end
  endtask

  initial begin
    ledger = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: migration, missing candidate, redispatch, ties, spare codes
    write_regs(8'd1, 16'd0);
    send_word(mk(ACT_DISPATCH, 6'd0, 3'd3, 1'b0), 24);
    send_word(mk(ACT_DISPATCH, 6'd1, 3'd3, 1'b1), 24);
    send_word(mk(ACT_DISPATCH, 6'd63, 3'd3, 1'b0), 24);
    send_word(mk(ACT_SET_RUN, 6'd1, 3'd0, 1'b1), 24);
    send_word(mk(ACT_SET_RUN, 6'd63, 3'd7, 1'b1), 24);
    send_word(mk(ACT_SET_RUN, 6'd0, 3'd0, 1'b0), 24);
    send_word(mk(ACT_CHECK, 6'd0, 3'd0, 1'b0), 24);
    send_word(mk(ACT_CLEAR, 6'd63, 3'd0, 1'b0), 24);
    send_word(mk(ACT_CHECK, 6'd63, 3'd7, 1'b1), 24);
    send_word(mk(ACT_DISPATCH, 6'd0, 3'd3, 1'b0), 24);
    send_word(mk(ACT_DISPATCH, 6'd63, 3'd7, 1'b1), 24);
    send_word(mk(ACT_DISPATCH, 6'd10, 3'd5, 1'b0), 24);
    send_word(mk(ACT_DISPATCH, 6'd11, 3'd5, 1'b0), 24);
    send_word(mk(ACT_SET_RUN, 6'd11, 3'd0, 1'b1), 24);
    send_word(mk(ACT_CHECK, 6'd0, 3'd0, 1'b0), 24);
    send_word(mk(ACT_CHECK, 6'd0, 3'd5, 1'b0), 24);
    send_word(mk(ACT_SPARE_FIRST, 6'd63, 3'd7, 1'b1), 24);
    send_word(mk(ACT_SPARE_LAST, 6'd0, 3'd0, 1'b0), 24);
    send_word(mk(ACT_TICK, 6'd63, 3'd7, 1'b1), 24);
    send_word(mk(ACT_CHECK, 6'd42, 3'd1, 1'b1), 24);
    settle();

    // directed: cooldown hold-off, zero threshold, busiest below own load
    write_regs(8'd0, 16'd3);
    send_word(mk(ACT_CHECK, 6'd0, 3'd5, 1'b0), 0);
    send_word(mk(ACT_SET_RUN, 6'd0, 3'd0, 1'b1), 0);
    send_word(mk(ACT_TICK, 6'd0, 3'd0, 1'b0), 0);
    send_word(mk(ACT_TICK, 6'd0, 3'd0, 1'b0), 0);
    send_word(mk(ACT_CHECK, 6'd0, 3'd5, 1'b0), 0);
    repeat (3) send_word(mk(ACT_TICK, 6'd0, 3'd0, 1'b0), 0);
    send_word(mk(ACT_CHECK, 6'd0, 3'd5, 1'b0), 0);
    settle();

    // random phases; sender idles 24 then 76 percent, then not at all
    write_regs(8'd1, 16'd0);
    run_random(200, 24);
    settle();
    write_regs(8'd255, 16'hFFFF);
    run_random(60, 24);
    settle();
    write_regs(8'd0, 16'd1);
    run_random(200, 76);
    settle();
    write_regs(8'd2, 16'd3);
    run_random(150, 76);
    settle();
    write_regs(8'($urandom_range(1, 4)), 16'($urandom_range(0, 5)));
    run_random(240, 0);
    settle();

    repeat (20) @(posedge clk);
    if (ledger.owed.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, ledger.owed.size());
      ledger.failures++;
    end
    if (ledger.failures == 0) begin
      $display("cpu_load_affinity_balancer_unit_tb: clean");
    end else begin
      $display("cpu_load_affinity_balancer_unit_tb: errors");
    end
    $finish;
  end

endmodule
